// File: rtl/touch_panel_scan_sequencer_unit_defines.svh
// ----------------------------------------------------------------------------
// Touch panel scan sequencer assertion macros
// Shared concurrent assertion shorthands for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PANEL_SCAN_SEQUENCER_UNIT_DEFINES_SVH
`define TOUCH_PANEL_SCAN_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define TPSS_ASSERT_NOW(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("tpss: assertion failed");

// Next-cycle implication, disabled while in reset.
`define TPSS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("tpss: assertion failed");

`endif

// File: rtl/tpss_pkg.sv
// ----------------------------------------------------------------------------
// Touch panel scan sequencer package
// Types, codes and constants shared by the sequencer files.
// ----------------------------------------------------------------------------
package tpss_pkg;

	localparam int ADC_W   = 12;
	localparam int RETRY_W = 4;
	localparam int CMD_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Control byte fields of the converter
	localparam logic [CMD_W-1:0] CB_START   = 8'h80;
	localparam logic [CMD_W-1:0] CB_SEL_Z1  = 8'h30;
	localparam logic [CMD_W-1:0] CB_SEL_X   = 8'h50;
	localparam logic [CMD_W-1:0] CB_SEL_Y   = 8'h10;
	localparam logic [CMD_W-1:0] CB_PWR_ADC = 8'h01;
	localparam logic [CMD_W-1:0] CB_PWR_REF = 8'h02;

	localparam logic [CMD_W-1:0] CMD_Z1 = CB_START | CB_SEL_Z1 | CB_PWR_ADC | CB_PWR_REF;
	localparam logic [CMD_W-1:0] CMD_X  = CB_START | CB_SEL_X  | CB_PWR_ADC | CB_PWR_REF;
	localparam logic [CMD_W-1:0] CMD_Y  = CB_START | CB_SEL_Y  | CB_PWR_ADC | CB_PWR_REF;
	localparam logic [CMD_W-1:0] CMD_PD = CB_START | CB_SEL_Z1;
	localparam logic [CMD_W-1:0] CMD_NONE = 8'h00;

	// Register reset values
	localparam logic [ADC_W-1:0]   RST_SETTLE_TOL  = 12'd8;
	localparam logic [RETRY_W-1:0] RST_SETTLE_RETR = 4'd10;
	localparam logic [ADC_W-1:0]   RST_MIN_PRESS   = 12'd10;
	localparam logic [ADC_W-1:0]   RST_X_LIMIT     = 12'd4095;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTLE_TOL  = 2'd0,
		CFG_SETTLE_RETR = 2'd1,
		CFG_MIN_PRESS   = 2'd2,
		CFG_X_LIMIT     = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		OP_START = 1'b0,
		OP_WORD  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_Z1A_SKIP = 4'd1,
		PH_Z1A      = 4'd2,
		PH_X_FIRST  = 4'd3,
		PH_X_S0     = 4'd4,
		PH_X_S      = 4'd5,
		PH_Y_FIRST  = 4'd6,
		PH_Y_S0     = 4'd7,
		PH_Y_S      = 4'd8,
		PH_Z1B_SKIP = 4'd9,
		PH_Z1B      = 4'd10,
		PH_PD       = 4'd11
	} phase_t;

	typedef struct packed {
		logic [ADC_W-1:0]   settle_tol;
		logic [RETRY_W-1:0] settle_retr;
		logic [ADC_W-1:0]   min_press;
		logic [ADC_W-1:0]   x_limit;
	} cfg_t;

	typedef struct packed {
		logic             op;
		logic [ADC_W-1:0] adc_value;
	} item_t;

	typedef struct packed {
		logic             is_report;
		logic [CMD_W-1:0] command;
		logic [ADC_W-1:0] pos_x;
		logic [ADC_W-1:0] pos_y;
		logic             touched;
	} res_t;

endpackage

// File: rtl/tpss_sample_if.sv
// ----------------------------------------------------------------------------
// Sample channel
// Start requests and returned converter words, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpss_sample_if;
	import tpss_pkg::*;

	logic             valid;
	logic             ready;
	logic             op;
	logic [ADC_W-1:0] adc_value;

	modport source (output valid, output op, output adc_value, input ready);
	modport sink   (input valid, input op, input adc_value, output ready);
endinterface

// File: rtl/tpss_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Command bytes and final position reports, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tpss_result_if;
	import tpss_pkg::*;

	logic             valid;
	logic             ready;
	logic             is_report;
	logic [CMD_W-1:0] command;
	logic [ADC_W-1:0] pos_x;
	logic [ADC_W-1:0] pos_y;
	logic             touched;

	modport source (output valid, output is_report, output command, output pos_x,
		output pos_y, output touched, input ready);
	modport sink   (input valid, input is_report, input command, input pos_x,
		input pos_y, input touched, output ready);
endinterface

// File: rtl/touch_panel_scan_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Touch panel scan sequencer
// Drives one settle-and-validate scan of a 12-bit resistive touch converter.
// ----------------------------------------------------------------------------
// Usage:
//   sample: a request with op = 0 starts a scan (pen event or poll tick);
//   op = 1 returns the converter word for the last command issued.
//   result: one item per request at most; is_report = 0 carries a control
//   byte to send, is_report = 1 the final position report. A word that
//   arrives while no scan runs gives no result.
//   cfg_we / cfg_index / cfg_data write the settle tolerance, retry limit,
//   minimum pressure and X limit; write only while the block is idle.
// Timing:
//   a request passes an input register, the state machine and a result
//   register, in that order. One request is taken per cycle while the
//   result channel does not stall; the state update in the scan state
//   machine is the loop that sets this.
// Reset clears both stage valids, returns the scan to idle and loads the
// register defaults. When the receiver stalls, the result register holds,
// the input register fills, and sample.ready drops until result.ready returns.
// ----------------------------------------------------------------------------
`include "touch_panel_scan_sequencer_unit_defines.svh"

module touch_panel_scan_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	tpss_sample_if.sink                     sample,
	tpss_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [tpss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpss_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tpss_pkg::*;

	cfg_t  cfg;
	logic  v_s1;
	item_t item_s1;
	logic  v_s2;
	res_t  res_s2;
	logic  adv;
	logic  fsm_valid;
	res_t  fsm_res;

	tpss_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	// advance the held request when the result register can take its outcome
	assign adv          = v_s1 && (!v_s2 || result.ready);
	assign sample.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (sample.ready)
			v_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			item_s1.op        <= sample.op;
			item_s1.adc_value <= sample.adc_value;
		end
	end

	tpss_scan_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.step      (adv),
		.item      (item_s1),
		.res_valid (fsm_valid),
		.res       (fsm_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else if (adv)
			v_s2 <= fsm_valid;
		else if (result.ready)
			v_s2 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= fsm_res;
	end

	assign result.valid     = v_s2;
	assign result.is_report = res_s2.is_report;
	assign result.command   = res_s2.command;
	assign result.pos_x     = res_s2.pos_x;
	assign result.pos_y     = res_s2.pos_y;
	assign result.touched   = res_s2.touched;

	`TPSS_ASSERT_NOW(a_report_no_cmd, clk, arst_n, v_s2 && res_s2.is_report,
		res_s2.command == CMD_NONE)
	`TPSS_ASSERT_NOW(a_cmd_no_pos, clk, arst_n, v_s2 && !res_s2.is_report,
		!res_s2.touched && res_s2.pos_x == '0 && res_s2.pos_y == '0)
	`TPSS_ASSERT_NOW(a_touch_pos, clk, arst_n, v_s2 && res_s2.touched,
		res_s2.pos_x != '0 && res_s2.pos_y != '0)
	`TPSS_ASSERT_NEXT(a_stall_holds_s1, clk, arst_n, v_s1 && !adv,
		v_s1 && $stable(item_s1))
endmodule

// File: rtl/tpss_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only settle, pressure and limit registers of the sequencer.
// ----------------------------------------------------------------------------
module tpss_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [tpss_pkg::CFG_IDX_W-1:0]  index,
	input  logic [tpss_pkg::CFG_DATA_W-1:0] data,
	output tpss_pkg::cfg_t                cfg
);
	import tpss_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_tol  <= RST_SETTLE_TOL;
			cfg_q.settle_retr <= RST_SETTLE_RETR;
			cfg_q.min_press   <= RST_MIN_PRESS;
			cfg_q.x_limit     <= RST_X_LIMIT;
		end else if (we) begin
			unique case (cfg_idx_t'(index))
				CFG_SETTLE_TOL:  cfg_q.settle_tol  <= data[ADC_W-1:0];
				CFG_SETTLE_RETR: cfg_q.settle_retr <= data[RETRY_W-1:0];
				CFG_MIN_PRESS:   cfg_q.min_press   <= data[ADC_W-1:0];
				CFG_X_LIMIT:     cfg_q.x_limit     <= data[ADC_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;
endmodule

// File: rtl/tpss_scan_fsm.sv
// ----------------------------------------------------------------------------
// Scan state machine
// Phase sequencing, settle check and report formation; while step is high, one item a cycle.
// ----------------------------------------------------------------------------
`include "touch_panel_scan_sequencer_unit_defines.svh"

module tpss_scan_fsm (
	input  logic            clk,
	input  logic            arst_n,
	input  tpss_pkg::cfg_t  cfg,
	input  logic            step,
	input  tpss_pkg::item_t item,
	output logic            res_valid,
	output tpss_pkg::res_t  res
);
	import tpss_pkg::*;

	phase_t             phase_q, phase_d;
	logic [ADC_W-1:0]   prev_q, prev_d;
	logic [ADC_W-1:0]   x_q, x_d;
	logic [ADC_W-1:0]   y_q, y_d;
	logic [ADC_W-1:0]   fp_q, fp_d;
	logic [RETRY_W-1:0] retry_q, retry_d;
	logic               err_q, err_d;

	logic [ADC_W-1:0] w;
	logic [ADC_W-1:0] diff;
	logic             close;
	logic             first_read;
	logic             settle_done;
	logic             pressed;
	logic             down;

	assign w    = item.adc_value;
	assign diff = (prev_q > w) ? (prev_q - w) : (w - prev_q);
	assign close = diff < cfg.settle_tol;
	assign first_read = (phase_q == PH_X_S0) || (phase_q == PH_Y_S0);
	assign settle_done = close || (!first_read && (retry_q >= cfg.settle_retr));
	assign pressed = (fp_q != '0) && (w != '0);
	assign down    = (x_q != '0) && (y_q != '0);

	// Next state
	always_comb begin
		phase_d = phase_q;
		prev_d  = prev_q;
		x_d     = x_q;
		y_d     = y_q;
		fp_d    = fp_q;
		retry_d = retry_q;
		err_d   = err_q;
		if (item.op == OP_START) begin
			phase_d = PH_Z1A_SKIP;
			prev_d  = '0;
			x_d     = '0;
			y_d     = '0;
			fp_d    = '0;
			retry_d = '0;
			err_d   = 1'b0;
		end else begin
			unique case (phase_q)
				PH_Z1A_SKIP: phase_d = PH_Z1A;
				PH_Z1A: begin
					fp_d    = w;
					phase_d = PH_X_FIRST;
				end
				PH_X_FIRST, PH_Y_FIRST: begin
					prev_d = w;
					if (phase_q == PH_X_FIRST) begin
						x_d     = w;
						phase_d = PH_X_S0;
					end else begin
						y_d     = w;
						phase_d = err_q ? PH_Z1B_SKIP : PH_Y_S0;
					end
				end
				PH_X_S0, PH_X_S, PH_Y_S0, PH_Y_S: begin
					prev_d = w;
					if (phase_q == PH_X_S0 || phase_q == PH_X_S)
						x_d = w;
					else
						y_d = w;
					// first miss restarts the count, later misses use it up
					if (!close) begin
						if (first_read)
							retry_d = '0;
						else if (retry_q >= cfg.settle_retr)
							err_d = 1'b1;
						else
							retry_d = retry_q + 1'b1;
					end
					if (phase_q == PH_X_S0 || phase_q == PH_X_S)
						phase_d = settle_done ? PH_Y_FIRST : PH_X_S;
					else
						phase_d = settle_done ? PH_Z1B_SKIP : PH_Y_S;
				end
				PH_Z1B_SKIP: phase_d = PH_Z1B;
				PH_Z1B: begin
					if (pressed && ((fp_q < cfg.min_press) || (w < cfg.min_press)
							|| (x_q >= cfg.x_limit)))
						err_d = 1'b1;
					if (err_d || !pressed) begin
						x_d = '0;
						y_d = '0;
					end
					phase_d = PH_PD;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// Result
	always_comb begin
		res_valid     = 1'b1;
		res.is_report = 1'b0;
		res.command   = CMD_NONE;
		res.pos_x     = '0;
		res.pos_y     = '0;
		res.touched   = 1'b0;
		if (item.op == OP_START) begin
			res.command = CMD_Z1;
		end else begin
			unique case (phase_q)
				PH_Z1A_SKIP: res.command = CMD_Z1;
				PH_Z1A:      res.command = CMD_X;
				PH_X_FIRST:  res.command = CMD_X;
				PH_X_S0, PH_X_S: res.command = settle_done ? CMD_Y : CMD_X;
				PH_Y_FIRST:  res.command = err_q ? CMD_Z1 : CMD_Y;
				PH_Y_S0, PH_Y_S: res.command = settle_done ? CMD_Z1 : CMD_Y;
				PH_Z1B_SKIP: res.command = CMD_Z1;
				PH_Z1B:      res.command = CMD_PD;
				PH_PD: begin
					res.is_report = 1'b1;
					res.pos_x     = down ? x_q : '0;
					res.pos_y     = down ? y_q : '0;
					res.touched   = down;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			prev_q  <= '0;
			x_q     <= '0;
			y_q     <= '0;
			fp_q    <= '0;
			retry_q <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			prev_q  <= prev_d;
			x_q     <= x_d;
			y_q     <= y_d;
			fp_q    <= fp_d;
			retry_q <= retry_d;
			err_q   <= err_d;
		end
	end

	`TPSS_ASSERT_NEXT(a_start_restarts, clk, arst_n, step && item.op == OP_START,
		phase_q == PH_Z1A_SKIP && !err_q && retry_q == '0)
	`TPSS_ASSERT_NOW(a_err_clears_on_start, clk, arst_n, $fell(err_q),
		$past(step) && $past(item.op) == OP_START)
	`TPSS_ASSERT_NOW(a_no_result_idle, clk, arst_n, step && !res_valid,
		item.op == OP_WORD && phase_q == PH_IDLE || phase_q > PH_PD)
endmodule

// File: tb/sv/touch_panel_scan_sequencer_unit_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch panel scan sequencer checker
// Follows the sample, result and register ports, keeps its own copy of the
// scan state and registers, works out the command or report that each
// request should give and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module touch_panel_scan_sequencer_unit_chk
	import tpss_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	tpss_sample_if                sample,
	tpss_result_if                result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    fail_count,
	output int                    pending
);

	cfg_t               regs;
	phase_t             scan_ph;
	logic [ADC_W-1:0]   last_word;
	logic [ADC_W-1:0]   x_pos;
	logic [ADC_W-1:0]   y_pos;
	logic [ADC_W-1:0]   press_a;
	logic [RETRY_W-1:0] retry_cnt;
	logic               settle_err;
	res_t               due_results[$];

	function automatic res_t command_out(input logic [CMD_W-1:0] code);
		res_t r;
		r = '0;
		r.is_report = 1'b0;
		r.command = code;
		return r;
	endfunction

	// One settling read of the current axis; done once settled or out of retries.
	task automatic settle_read(input logic [ADC_W-1:0] w, input bit first_read,
		output bit done);
		logic [ADC_W-1:0] diff;
		diff = (last_word > w) ? last_word - w : w - last_word;
		last_word = w;
		done = 1'b0;
		if (diff < regs.settle_tol)
			done = 1'b1;
		else if (first_read)
			retry_cnt = '0;
		else if (retry_cnt >= regs.settle_retr) begin
			settle_err = 1'b1;
			done = 1'b1;
		end else
			retry_cnt = retry_cnt + 1'b1;
	endtask

	task automatic advance_scan(input op_t op, input logic [ADC_W-1:0] w,
		output bit fired, output res_t r);
		bit done;
		bit pressed;
		bit down;
		fired = 1'b1;
		r = command_out(CMD_NONE);
		if (op == OP_START) begin
			last_word = '0;
			x_pos = '0;
			y_pos = '0;
			press_a = '0;
			retry_cnt = '0;
			settle_err = 1'b0;
			scan_ph = PH_Z1A_SKIP;
			r = command_out(CMD_Z1);
		end else begin
			case (scan_ph)
				PH_Z1A_SKIP: begin
					scan_ph = PH_Z1A;
					r = command_out(CMD_Z1);
				end
				PH_Z1A: begin
					press_a = w;
					scan_ph = PH_X_FIRST;
					r = command_out(CMD_X);
				end
				PH_X_FIRST: begin
					last_word = w;
					x_pos = w;
					scan_ph = PH_X_S0;
					r = command_out(CMD_X);
				end
				PH_X_S0, PH_X_S: begin
					settle_read(w, scan_ph == PH_X_S0, done);
					x_pos = last_word;
					if (done) begin
						scan_ph = PH_Y_FIRST;
						r = command_out(CMD_Y);
					end else begin
						scan_ph = PH_X_S;
						r = command_out(CMD_X);
					end
				end
				PH_Y_FIRST: begin
					last_word = w;
					y_pos = w;
					// skip Y settling once X has failed to settle
					if (settle_err) begin
						scan_ph = PH_Z1B_SKIP;
						r = command_out(CMD_Z1);
					end else begin
						scan_ph = PH_Y_S0;
						r = command_out(CMD_Y);
					end
				end
				PH_Y_S0, PH_Y_S: begin
					settle_read(w, scan_ph == PH_Y_S0, done);
					y_pos = last_word;
					if (done) begin
						scan_ph = PH_Z1B_SKIP;
						r = command_out(CMD_Z1);
					end else begin
						scan_ph = PH_Y_S;
						r = command_out(CMD_Y);
					end
				end
				PH_Z1B_SKIP: begin
					scan_ph = PH_Z1B;
					r = command_out(CMD_Z1);
				end
				PH_Z1B: begin
					pressed = (press_a != '0) && (w != '0);
					if (pressed) begin
						if (press_a < regs.min_press || w < regs.min_press)
							settle_err = 1'b1;
						if (x_pos >= regs.x_limit)
							settle_err = 1'b1;
					end
					if (settle_err || !pressed) begin
						x_pos = '0;
						y_pos = '0;
					end
					scan_ph = PH_PD;
					r = command_out(CMD_PD);
				end
				PH_PD: begin
					down = (x_pos != '0) && (y_pos != '0);
					r.is_report = 1'b1;
					r.command = CMD_NONE;
					r.pos_x = down ? x_pos : '0;
					r.pos_y = down ? y_pos : '0;
					r.touched = down;
					scan_ph = PH_IDLE;
				end
				default: begin
					// word with no scan running: dropped silently
					scan_ph = PH_IDLE;
					fired = 1'b0;
				end
			endcase
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t got;
		res_t want;
		bit fired;
		if (!arst_n) begin
			regs.settle_tol = RST_SETTLE_TOL;
			regs.settle_retr = RST_SETTLE_RETR;
			regs.min_press = RST_MIN_PRESS;
			regs.x_limit = RST_X_LIMIT;
			scan_ph = PH_IDLE;
			last_word = '0;
			x_pos = '0;
			y_pos = '0;
			press_a = '0;
			retry_cnt = '0;
			settle_err = 1'b0;
			due_results.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// a result is registered after its request is taken, so compare first
			if (result.valid && result.ready) begin
				got = res_t'({result.is_report, result.command, result.pos_x,
					result.pos_y, result.touched});
				if (due_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result report=%0d cmd=%h x=%0d y=%0d touched=%0d",
							$realtime, got.is_report, got.command, got.pos_x, got.pos_y,
							got.touched);
				end else begin
					want = due_results.pop_front();
					if (got.is_report !== want.is_report || got.command !== want.command ||
						got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
						got.touched !== want.touched) begin
						fail_count++;
						if (fail_count <= 10)
							$display({"%0t: mismatch expected report=%0d cmd=%h x=%0d y=%0d ",
								"touched=%0d, got report=%0d cmd=%h x=%0d y=%0d touched=%0d"},
								$realtime, want.is_report, want.command, want.pos_x,
								want.pos_y, want.touched, got.is_report, got.command,
								got.pos_x, got.pos_y, got.touched);
					end
				end
			end
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_SETTLE_TOL:  regs.settle_tol = cfg_data;
					CFG_SETTLE_RETR: regs.settle_retr = cfg_data[RETRY_W-1:0];
					CFG_MIN_PRESS:   regs.min_press = cfg_data;
					CFG_X_LIMIT:     regs.x_limit = cfg_data;
					default: ;
				endcase
			end
			if (sample.valid && sample.ready) begin
				advance_scan(op_t'(sample.op), sample.adc_value, fired, want);
				if (fired)
					due_results.push_back(want);
			end
			pending = due_results.size();
		end
	end

endmodule

// File: tb/sv/touch_panel_scan_sequencer_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Touch panel scan sequencer testbench
// Plays the touch converter: answers each command the block issues with a
// word near a per-scan target, mixed with blind scans, aborted scans and
// stray requests, under several register settings and random stalls on both
// channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module touch_panel_scan_sequencer_unit_tb;
	import tpss_pkg::*;

	localparam int CYCLE_LIMIT    = 600000;
	localparam int ITEM_TARGET    = 1950;
	localparam int PHASE_LEN      = 250;
	localparam int CALM_FROM      = 1700;
	localparam int SCAN_WORDS_MAX = 48;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	tpss_sample_if sample_ch();
	tpss_result_if result_ch();

	int fail_count;
	int pending;
	int cycle_count = 0;
	int results_taken = 0;
	bit calm = 1'b0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;

	logic             last_is_report = 1'b0;
	logic [CMD_W-1:0] last_cmd = CMD_NONE;
	logic [ADC_W-1:0] cur_tol = RST_SETTLE_TOL;
	logic [ADC_W-1:0] cur_minp = RST_MIN_PRESS;
	logic [ADC_W-1:0] cur_xlim = RST_X_LIMIT;
	logic [ADC_W-1:0] press_base;
	logic [ADC_W-1:0] x_aim;
	logic [ADC_W-1:0] y_aim;
	int               spread;

	touch_panel_scan_sequencer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	touch_panel_scan_sequencer_unit_chk scan_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample_ch),
		.result     (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Track the last command handed over, so the converter can answer it.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_taken <= results_taken + 1;
			last_is_report <= result_ch.is_report;
			last_cmd <= result_ch.command;
		end
	end

	initial begin
		int stall;
		stall = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall > 0) begin
				stall--;
				result_ch.ready = 1'b0;
			end else if (!calm && !rx_steady && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 18) - 1;
				result_ch.ready = 1'b0;
			end else
				result_ch.ready = 1'b1;
			if ($urandom_range(0, 199) == 0)
				rx_steady = !rx_steady;
		end
	end

	function automatic logic [ADC_W-1:0] near(input logic [ADC_W-1:0] aim);
		int v;
		v = int'(aim) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return ADC_W'(v);
	endfunction

	function automatic logic [ADC_W-1:0] pick_aim();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return cur_xlim;
			3: return cur_xlim - 1'b1;
			4: return ADC_W'($urandom_range(1, 3));
			default: return ADC_W'($urandom);
		endcase
	endfunction

	function automatic logic [ADC_W-1:0] pick_press();
		case ($urandom_range(0, 9))
			0: return '0;
			1, 2: return ADC_W'($urandom_range(0, 40));
			3: return cur_minp;
			default: return ADC_W'($urandom);
		endcase
	endfunction

	function automatic int pick_spread();
		int s;
		case ($urandom_range(0, 5))
			0: s = 0;
			1: s = (cur_tol > 0) ? int'(cur_tol) - 1 : 0;
			2: s = int'(cur_tol);
			3: s = 2 * int'(cur_tol);
			4: s = int'(cur_tol) / 2;
			default: s = $urandom_range(0, 4095);
		endcase
		return (s > 4095) ? 4095 : s;
	endfunction

	// Converter answer to the last command.
	function automatic logic [ADC_W-1:0] answer(input logic [CMD_W-1:0] cmd);
		case (cmd)
			CMD_Z1: return ($urandom_range(0, 4) == 0) ? ADC_W'($urandom) : press_base;
			CMD_X:  return near(x_aim);
			CMD_Y:  return near(y_aim);
			default: return ADC_W'($urandom);
		endcase
	endfunction

	// Hold the request until it is taken; returns at a falling edge, valid still high.
	task automatic send(input op_t op, input logic [ADC_W-1:0] w);
		if (!calm && !tx_steady && $urandom_range(0, 5) == 0) begin
			sample_ch.valid = 1'b0;
			repeat ($urandom_range(1, 18)) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.op = op;
		sample_ch.adc_value = w;
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic drain();
		sample_ch.valid = 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic apply_settings(input logic [ADC_W-1:0] tol,
		input logic [RETRY_W-1:0] retr, input logic [ADC_W-1:0] minp,
		input logic [ADC_W-1:0] xlim);
		drain();
		// a stray word gives no result and may still be in flight
		repeat (4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = CFG_SETTLE_TOL;
		cfg_data = tol;
		@(negedge clk);
		cfg_index = CFG_SETTLE_RETR;
		cfg_data = {(CFG_DATA_W - RETRY_W)'($urandom), retr};
		@(negedge clk);
		cfg_index = CFG_MIN_PRESS;
		cfg_data = minp;
		@(negedge clk);
		cfg_index = CFG_X_LIMIT;
		cfg_data = xlim;
		@(negedge clk);
		cfg_we = 1'b0;
		cur_tol = tol;
		cur_minp = minp;
		cur_xlim = xlim;
	endtask

	// Answer every command until the report, or drop the scan early now and then.
	task automatic adc_scan();
		int base;
		int n;
		int stop_at;
		press_base = pick_press();
		x_aim = pick_aim();
		y_aim = pick_aim();
		spread = pick_spread();
		stop_at = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : SCAN_WORDS_MAX;
		drain();
		base = results_taken;
		send(OP_START, ADC_W'($urandom));
		n = 1;
		while (n < stop_at) begin
			sample_ch.valid = 1'b0;
			while (results_taken != base + n) @(negedge clk);
			if (last_is_report)
				break;
			send(OP_WORD, answer(last_cmd));
			n++;
		end
	endtask

	// Back-to-back words around one level, without waiting for the commands.
	task automatic blind_scan();
		logic [ADC_W-1:0] level;
		level = pick_aim();
		spread = pick_spread();
		send(OP_START, ADC_W'($urandom));
		repeat ($urandom_range(6, 24))
			send(OP_WORD, ($urandom_range(0, 3) == 0) ? ADC_W'($urandom) : near(level));
	endtask

	task automatic stray_requests();
		repeat ($urandom_range(1, 6))
			send(($urandom_range(0, 3) == 0) ? OP_START : OP_WORD, ADC_W'($urandom));
	endtask

	initial begin
		int phase_no;
		int kind;
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.op = OP_START;
		sample_ch.adc_value = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_SETTLE_TOL;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// word with no scan running
		send(OP_WORD, 12'hFFF);
		// clean scan: both axes settle at once, pen down
		send(OP_START, 12'h000);
		send(OP_WORD, 12'h000);
		send(OP_WORD, 12'hFFF);
		send(OP_WORD, 12'd1000);
		send(OP_WORD, 12'd1003);
		send(OP_WORD, 12'd2000);
		send(OP_WORD, 12'd2005);
		send(OP_WORD, 12'h555);
		send(OP_WORD, 12'hAAA);
		send(OP_WORD, 12'h123);
		// restart mid-scan, zero pressure, X at the limit: release
		send(OP_START, 12'hFFF);
		send(OP_START, 12'h5A5);
		send(OP_WORD, 12'h000);
		send(OP_WORD, 12'h000);
		send(OP_WORD, 12'hFFF);
		send(OP_WORD, 12'hFFF);
		send(OP_WORD, 12'h000);
		send(OP_WORD, 12'h000);
		send(OP_WORD, 12'd7);
		send(OP_WORD, 12'hFFF);
		send(OP_WORD, 12'hAAA);

		phase_no = 0;
		while (results_taken < ITEM_TARGET) begin
			if (results_taken >= phase_no * PHASE_LEN) begin
				phase_no++;
				case (phase_no)
					1: apply_settings('0, '0, '0, '0);
					2: apply_settings('1, '1, '1, '1);
					7, 8: apply_settings(RST_SETTLE_TOL, RST_SETTLE_RETR, RST_MIN_PRESS,
						RST_X_LIMIT);
					default: apply_settings(
						($urandom_range(0, 3) == 0) ? ADC_W'($urandom) :
							ADC_W'($urandom_range(1, 40)),
						RETRY_W'($urandom_range(0, 15)),
						($urandom_range(0, 3) == 0) ? ADC_W'($urandom) :
							ADC_W'($urandom_range(0, 60)),
						($urandom_range(0, 1) == 0) ? 12'hFFF :
							ADC_W'($urandom_range(1000, 4095)));
				endcase
			end
			calm = (results_taken >= CALM_FROM);
			if ($urandom_range(0, 9) == 0)
				tx_steady = !tx_steady;
			kind = $urandom_range(0, 19);
			if (kind < 13)
				adc_scan();
			else if (kind < 17)
				blind_scan();
			else
				stray_requests();
		end

		calm = 1'b1;
		drain();
		repeat (8) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/tpss_pkg.sv
rtl/tpss_sample_if.sv
rtl/tpss_result_if.sv
rtl/tpss_cfg_regs.sv
rtl/tpss_scan_fsm.sv
rtl/touch_panel_scan_sequencer_unit.sv
tb/sv/touch_panel_scan_sequencer_unit_chk.sv
tb/sv/touch_panel_scan_sequencer_unit_tb.sv
